### design/humidity_temp_frame_decoder_unit_assert.svh
// Assertion macros for the frame decoder unit.
// Expects clk and arst_n in the scope of use.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_UNIT_ASSERT_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_UNIT_ASSERT_SVH

// implication checked on every clock outside reset
`define HTFD_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence checked in the cycle after the antecedent
`define HTFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/htfd_pkg.sv
// Shared constants, stage types and CRC-8 function for the frame decoder.
// No dependencies.
package htfd_pkg;

	localparam logic [7:0]         CrcInit  = 8'hFF;
	localparam logic [7:0]         CrcPoly  = 8'h31;
	localparam logic [14:0]        TempSpan = 15'd17500;
	localparam logic [13:0]        HumSpan  = 14'd12500;
	localparam logic signed [15:0] TempBase = 16'sd4500;
	localparam logic [13:0]        HumBase  = 14'd600;
	localparam logic [13:0]        HumMax   = 14'd10000;
	localparam logic [16:0]        RawFull  = 17'd65535;

	localparam int TProdW = 31;
	localparam int HProdW = 30;

	typedef struct packed {
		logic [7:0]        temp_crc;
		logic [7:0]        hum_crc;
		logic [7:0]        temp_lsb;
		logic [7:0]        hum_lsb;
		logic [7:0]        temp_check;
		logic [7:0]        hum_check;
		logic [TProdW-1:0] temp_prod;
		logic [HProdW-1:0] hum_prod;
	} s1_word_t;

	typedef struct packed {
		logic        err;
		logic [14:0] temp_q;
		logic [13:0] hum_q;
	} s2_word_t;

	function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
		logic [7:0] c;
		c = crc_in ^ data;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

### design/htfd_frame_if.sv
// Input channel carrying one six-byte sensor frame per word.
// No dependencies.
interface htfd_frame_if;
	logic       valid;
	logic       ready;
	logic [7:0] temp_msb;
	logic [7:0] temp_lsb;
	logic [7:0] temp_check;
	logic [7:0] hum_msb;
	logic [7:0] hum_lsb;
	logic [7:0] hum_check;

	modport source (
		output valid, temp_msb, temp_lsb, temp_check, hum_msb, hum_lsb, hum_check,
		input  ready
	);
	modport sink (
		input  valid, temp_msb, temp_lsb, temp_check, hum_msb, hum_lsb, hum_check,
		output ready
	);
endinterface

### design/htfd_result_if.sv
// Output channel carrying one decoded measurement per word.
// No dependencies.
interface htfd_result_if;
	logic               valid;
	logic               ready;
	logic               status;
	logic signed [14:0] temperature_centi;
	logic [13:0]        humidity_centi;

	modport source (
		output valid, status, temperature_centi, humidity_centi,
		input  ready
	);
	modport sink (
		input  valid, status, temperature_centi, humidity_centi,
		output ready
	);
endinterface

### design/humidity_temp_frame_decoder_unit.sv
// Three-stage frame decoder: CRC-8 check and conversion of raw sensor words.
// Depends on htfd_pkg, htfd_frame_if, htfd_result_if and the assert header.
//
//   channel  | dir | payload
//   ---------+-----+---------------------------------------------------------
//   frame    | in  | temp_msb, temp_lsb, temp_check, hum_msb, hum_lsb, hum_check
//   result   | out | status, temperature_centi, humidity_centi
//
// One word enters per cycle while result.ready is high.
// Stage 1: CRC of the high bytes and the two span products. Stage 2: CRC of the
// low bytes, check compare and divide by 65535 as high half plus one compare.
// Stage 3: offset, clamp and zeroing on error, held in the output register.
// Each stage advances when it is empty or the stage after it advances.
// Reset clears the stage valid bits only.
module humidity_temp_frame_decoder_unit (
	input logic            clk,
	input logic            arst_n,
	htfd_frame_if.sink     frame,
	htfd_result_if.source  result
);

	logic                  v_s1, v_s2, v_s3;
	logic                  en1, en2, en3;
	htfd_pkg::s1_word_t    w_s1, w1_d;
	htfd_pkg::s2_word_t    w_s2, w2_d;
	logic                  status_s3;
	logic signed [14:0]    temp_s3, temp_d;
	logic [13:0]           hum_s3, hum_d;

	logic [15:0]           temp_raw, hum_raw;
	logic [7:0]            temp_crc_fin, hum_crc_fin;
	logic [14:0]           t_hi;
	logic [15:0]           t_lo;
	logic [13:0]           h_hi;
	logic [15:0]           h_lo;
	logic [16:0]           t_sum, h_sum;
	logic signed [15:0]    temp_wide;
	logic [13:0]           hum_off;

	assign en3 = !v_s3 || result.ready;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign frame.ready = en1;

	// stage 1
	always_comb begin
		temp_raw      = {frame.temp_msb, frame.temp_lsb};
		hum_raw       = {frame.hum_msb, frame.hum_lsb};
		w1_d.temp_crc = htfd_pkg::crc8_byte(htfd_pkg::CrcInit, frame.temp_msb);
		w1_d.hum_crc  = htfd_pkg::crc8_byte(htfd_pkg::CrcInit, frame.hum_msb);
		w1_d.temp_lsb   = frame.temp_lsb;
		w1_d.hum_lsb    = frame.hum_lsb;
		w1_d.temp_check = frame.temp_check;
		w1_d.hum_check  = frame.hum_check;
		w1_d.temp_prod  = htfd_pkg::TProdW'(temp_raw) * htfd_pkg::TProdW'(htfd_pkg::TempSpan);
		w1_d.hum_prod   = htfd_pkg::HProdW'(hum_raw) * htfd_pkg::HProdW'(htfd_pkg::HumSpan);
	end

	// stage 2: x / 65535 = hi + ((hi + lo) >= 65535)
	always_comb begin
		temp_crc_fin = htfd_pkg::crc8_byte(w_s1.temp_crc, w_s1.temp_lsb);
		hum_crc_fin  = htfd_pkg::crc8_byte(w_s1.hum_crc, w_s1.hum_lsb);
		w2_d.err     = (temp_crc_fin != w_s1.temp_check) || (hum_crc_fin != w_s1.hum_check);
		t_hi  = w_s1.temp_prod[30:16];
		t_lo  = w_s1.temp_prod[15:0];
		h_hi  = w_s1.hum_prod[29:16];
		h_lo  = w_s1.hum_prod[15:0];
		t_sum = 17'(t_hi) + 17'(t_lo);
		h_sum = 17'(h_hi) + 17'(h_lo);
		w2_d.temp_q = t_hi + 15'(t_sum >= htfd_pkg::RawFull);
		w2_d.hum_q  = h_hi + 14'(h_sum >= htfd_pkg::RawFull);
	end

	// stage 3
	always_comb begin
		temp_wide = $signed({1'b0, w_s2.temp_q}) - htfd_pkg::TempBase;
		hum_off   = w_s2.hum_q - htfd_pkg::HumBase;
		if (w_s2.err) begin
			temp_d = '0;
			hum_d  = '0;
		end else begin
			temp_d = temp_wide[14:0];
			if (w_s2.hum_q < htfd_pkg::HumBase) begin
				hum_d = '0;
			end else if (hum_off > htfd_pkg::HumMax) begin
				hum_d = htfd_pkg::HumMax;
			end else begin
				hum_d = hum_off;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= frame.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && frame.valid) w_s1 <= w1_d;
		if (en2 && v_s1) w_s2 <= w2_d;
		if (en3 && v_s2) begin
			status_s3 <= w_s2.err;
			temp_s3   <= temp_d;
			hum_s3    <= hum_d;
		end
	end

	assign result.valid             = v_s3;
	assign result.status            = status_s3;
	assign result.temperature_centi = temp_s3;
	assign result.humidity_centi    = hum_s3;

`include "humidity_temp_frame_decoder_unit_assert.svh"

	`HTFD_ASSERT_IMPLY(a_err_zero, v_s3 && status_s3,
		(temp_s3 == '0) && (hum_s3 == '0), "error word with nonzero values")
	`HTFD_ASSERT_IMPLY(a_hum_range, v_s3, hum_s3 <= htfd_pkg::HumMax, "humidity above clamp")
	`HTFD_ASSERT_IMPLY(a_temp_range, v_s3,
		(temp_s3 >= -15'sd4500) && (temp_s3 <= 15'sd13000), "temperature out of range")
	`HTFD_ASSERT_NEXT(a_s1_advance, v_s1 && en2, v_s2, "stage 1 word lost")

endmodule

### tb/humidity_temp_frame_decoder_unit_test.sv
// Self-checking testbench for the humidity/temperature frame decoder unit.
// Depends on htfd_frame_if, htfd_result_if and the unit under test; sends frames
// with random gaps and back-pressure and checks every decoded reading in order.
`timescale 1ns / 100ps

module humidity_temp_frame_decoder_unit_test;

	typedef struct packed {
		logic [7:0] temp_msb;
		logic [7:0] temp_lsb;
		logic [7:0] temp_check;
		logic [7:0] hum_msb;
		logic [7:0] hum_lsb;
		logic [7:0] hum_check;
	} sensor_frame_t;

	typedef struct packed {
		logic               status;
		logic signed [14:0] temperature_centi;
		logic [13:0]        humidity_centi;
	} reading_t;

	class decode_scoreboard;
		localparam int TEMP_SPAN = 17500;
		localparam int TEMP_BASE = 4500;
		localparam int HUM_SPAN  = 12500;
		localparam int HUM_BASE  = 600;
		localparam int HUM_TOP   = 10000;
		localparam int RAW_FULL  = 65535;

		reading_t expected_readings[$];
		int       mismatches;
		int       frames_noted;
		int       bad_frames;
		int       readings_checked;

		function new();
			mismatches       = 0;
			frames_noted     = 0;
			bad_frames       = 0;
			readings_checked = 0;
		endfunction

		function logic [7:0] word_check(input logic [7:0] hi, input logic [7:0] lo);
			logic [7:0]  c;
			logic [15:0] data;
			c    = 8'hFF;
			data = {hi, lo};
			for (int i = 0; i < 2; i++) begin
				c ^= data[15 - 8*i -: 8];
				for (int b = 0; b < 8; b++) begin
					c = c[7] ? ({c[6:0], 1'b0} ^ 8'h31) : {c[6:0], 1'b0};
				end
			end
			return c;
		endfunction

		function reading_t predict_reading(input sensor_frame_t f);
			reading_t r;
			int       t_raw;
			int       h_raw;
			int       t_val;
			int       h_val;
			r = '0;
			if (word_check(f.temp_msb, f.temp_lsb) != f.temp_check ||
			    word_check(f.hum_msb, f.hum_lsb) != f.hum_check) begin
				r.status = 1'b1;
				return r;
			end
			t_raw = {16'd0, f.temp_msb, f.temp_lsb};
			h_raw = {16'd0, f.hum_msb, f.hum_lsb};
			t_val = (TEMP_SPAN * t_raw) / RAW_FULL - TEMP_BASE;
			h_val = (HUM_SPAN * h_raw) / RAW_FULL - HUM_BASE;
			if (h_val < 0)
				h_val = 0;
			if (h_val > HUM_TOP)
				h_val = HUM_TOP;
			r.temperature_centi = t_val[14:0];
			r.humidity_centi    = h_val[13:0];
			return r;
		endfunction

		function void note_frame(input sensor_frame_t f);
			reading_t r;
			r = predict_reading(f);
			expected_readings.push_back(r);
			frames_noted++;
			if (r.status)
				bad_frames++;
		endfunction

		function void check_result(input reading_t got);
			reading_t want;
			readings_checked++;
			if (expected_readings.size() == 0) begin
				$error("reading with nothing pending: status %0d temperature %0d humidity %0d",
				       got.status, got.temperature_centi, got.humidity_centi);
				mismatches++;
				return;
			end
			want = expected_readings.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.temperature_centi !== want.temperature_centi) begin
				$error("temperature_centi: expected %0d, got %0d",
				       want.temperature_centi, got.temperature_centi);
				mismatches++;
			end
			if (got.humidity_centi !== want.humidity_centi) begin
				$error("humidity_centi: expected %0d, got %0d",
				       want.humidity_centi, got.humidity_centi);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_readings.size();
		endfunction
	endclass

	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 880;

	logic clk;
	logic arst_n;
	bit   steady;
	int   stall_cycles;

	decode_scoreboard sb;

	htfd_frame_if  frame_ch();
	htfd_result_if result_ch();

	humidity_temp_frame_decoder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.result (result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= steady || ($urandom_range(0, 99) >= 34);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			sb.check_result({result_ch.status, result_ch.temperature_centi,
			                 result_ch.humidity_centi});
		end
	end

	always @(posedge clk) begin
		if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	function automatic sensor_frame_t good_frame(input logic [15:0] t, input logic [15:0] h);
		sensor_frame_t f;
		f.temp_msb   = t[15:8];
		f.temp_lsb   = t[7:0];
		f.temp_check = sb.word_check(t[15:8], t[7:0]);
		f.hum_msb    = h[15:8];
		f.hum_lsb    = h[7:0];
		f.hum_check  = sb.word_check(h[15:8], h[7:0]);
		return f;
	endfunction

	function automatic logic [15:0] raw_sample();
		case ($urandom_range(0, 9))
			0:       return 16'($urandom_range(0, 15));
			1:       return 16'hFFFF - 16'($urandom_range(0, 15));
			2:       return 16'($urandom_range(3100, 3200));
			3:       return 16'($urandom_range(16800, 16900));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic sensor_frame_t corrupt_byte(input sensor_frame_t f);
		logic [47:0] bytes;
		logic [7:0]  mask;
		int          pos;
		bytes = f;
		mask  = 8'($urandom_range(1, 255));
		pos   = $urandom_range(0, 5);
		bytes[8*pos +: 8] ^= mask;
		return bytes;
	endfunction

	// drive one word and return at the edge that accepts it
	task automatic send_frame(input sensor_frame_t f);
		@(negedge clk);
		if (!steady) begin
			while ($urandom_range(0, 99) < 34) begin
				frame_ch.valid <= 1'b0;
				@(negedge clk);
			end
		end
		frame_ch.valid      <= 1'b1;
		frame_ch.temp_msb   <= f.temp_msb;
		frame_ch.temp_lsb   <= f.temp_lsb;
		frame_ch.temp_check <= f.temp_check;
		frame_ch.hum_msb    <= f.hum_msb;
		frame_ch.hum_lsb    <= f.hum_lsb;
		frame_ch.hum_check  <= f.hum_check;
		@(posedge clk);
		while (!frame_ch.ready)
			@(posedge clk);
		sb.note_frame(f);
	endtask

	// hold off the sender until every pending reading has come back
	task automatic drain_readings();
		@(negedge clk);
		frame_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	initial begin
		sensor_frame_t f;
		int            kind;

		sb           = new();
		steady       = 1'b0;
		stall_cycles = 0;
		arst_n              <= 1'b0;
		frame_ch.valid      <= 1'b0;
		frame_ch.temp_msb   <= '0;
		frame_ch.temp_lsb   <= '0;
		frame_ch.temp_check <= '0;
		frame_ch.hum_msb    <= '0;
		frame_ch.hum_lsb    <= '0;
		frame_ch.hum_check  <= '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		send_frame(good_frame(16'h0000, 16'h0000));
		send_frame(good_frame(16'hFFFF, 16'hFFFF));
		send_frame(good_frame(16'h0000, 16'hFFFF));
		send_frame(good_frame(16'hFFFF, 16'h0000));
		send_frame(good_frame(16'd16851, 16'd3145));
		send_frame(good_frame(16'd16852, 16'd3146));
		send_frame(good_frame(16'd16853, 16'd3147));
		send_frame(good_frame(16'h6666, 16'h8000));
		send_frame(good_frame(16'h5555, 16'hAAAA));
		f = good_frame(16'h1234, 16'h5678);
		f.temp_check ^= 8'h01;
		send_frame(f);
		f = good_frame(16'h1234, 16'h5678);
		f.hum_check ^= 8'h80;
		send_frame(f);
		f = good_frame(16'hBEEF, 16'hCAFE);
		f.temp_check ^= 8'hFF;
		f.hum_check  ^= 8'h5A;
		send_frame(f);
		f = good_frame(16'h4000, 16'hC000);
		f.temp_msb ^= 8'h10;
		send_frame(f);
		f = good_frame(16'h4000, 16'hC000);
		f.hum_lsb ^= 8'h01;
		send_frame(f);
		send_frame('0);
		send_frame('1);
		drain_readings();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			steady = (i >= 350 && i < 500);
			if (i == 200 || i == 650)
				drain_readings();
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				f = good_frame(raw_sample(), raw_sample());
			end else if (kind < 90) begin
				f = corrupt_byte(good_frame(raw_sample(), raw_sample()));
			end else begin
				f = {$urandom(), 16'($urandom())};
			end
			send_frame(f);
		end
		steady = 1'b0;

		@(negedge clk);
		frame_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("decoded %0d frames, %0d of them with a failing check byte",
		         sb.frames_noted, sb.bad_frames);
		$display("compared %0d readings under random gaps and back-pressure",
		         sb.readings_checked);
		if (sb.mismatches == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### files.f
+incdir+design
design/htfd_pkg.sv
design/htfd_frame_if.sv
design/htfd_result_if.sv
design/humidity_temp_frame_decoder_unit.sv
tb/humidity_temp_frame_decoder_unit_test.sv
